FILE: design/rspa_pkg.sv
// Shared types and constants for the ring slot pool allocator.
// Beat structs, slot state codes, op codes and controller/datapath links.
// No dependencies.
`default_nettype none

package rspa_pkg;

  localparam int SLOT_W   = 6;
  localparam int SLOT_CODES = 2 ** SLOT_W;
  localparam int CNT_W    = 7;
  localparam int CNT_MAX  = 127;
  localparam int SCAN_W   = 16;
  localparam int OFF_W    = 4;
  localparam int ROW_W    = 2 * SCAN_W;

  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_TAKEN = 2'd2;

  localparam logic [ROW_W-1:0] ROW_FULL = {SCAN_W{ST_FULL}};

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              found;
    logic [CNT_W-1:0]  full_slots;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic fail;
    logic next;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fast_fail;
    logic is_free;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/ring_slot_pool_allocator_top.sv
// Top level of the ring slot pool allocator.
// Joins rspa_ctrl and rspa_dp; uses rspa_pkg for beat and link types.
//
// Usage: drive in_item and raise start; the beat is taken at the edge
// where start is high and busy is low. Ops: fill the next empty slot,
// allocate the next full slot, free a given slot. Each beat gives exactly
// one result beat on out_item, marked by out_valid for one cycle; the
// receiver cannot stall and must take it then.
// Timing: slot states sit in a memory of 16-slot rows with a registered
// read port, scanned one row per cycle in ring order from the slot after
// the given one. Fill and alloc scan 1 to ceil(POOL_SLOTS/16) + 1 rows,
// i.e. 1 to 5 at 64 slots. Some beats fail at once: alloc with zero
// count, free beyond the pool, unused op. The result appears the cycle
// after the last work cycle, while busy is already low, so the next beat
// may be taken alongside it.
// Reset: synchronous, active low; every slot reads full (per-row valid
// bits, no clearing pass) and the full count is the pool size, capped at 127.
`default_nettype none

module ring_slot_pool_allocator_top #(
  parameter int POOL_SLOTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rspa_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output rspa_pkg::out_item_t      out_item
);
  import rspa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rspa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rspa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: design/rspa_ctrl.sv
// Sequencing controller for the ring slot pool allocator.
// Drives datapath commands from its status; uses rspa_pkg.
`default_nettype none

module rspa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rspa_pkg::dp_stat_t  stat,
  output rspa_pkg::ctrl_cmd_t      cmd
);
  import rspa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FREE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.fast_fail) begin
            state_nxt = S_IDLE;
          end else if (stat.is_free) begin
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.write = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.next  = 1'b1;
        end
      end
      S_FREE: begin
        cmd.write = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.fail, cmd.next, cmd.write}))
    else $error("controller issued more than one command");

  a_next_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next |-> (!stat.hit && !stat.last))
    else $error("scan advanced past a hit or the final row");

  a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(cmd.accept))
    else $error("busy rose without an accepted beat");
`endif

endmodule

`default_nettype wire

FILE: design/rspa_dp.sv
// Datapath for the ring slot pool allocator: slot state memory in rows of
// 16 slots, row scan with masked priority encode, full count, result beat.
// Uses rspa_pkg; commanded by rspa_ctrl.
`default_nettype none

module rspa_dp #(
  parameter int POOL_SLOTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rspa_pkg::in_item_t  in_item,
  input  wire rspa_pkg::ctrl_cmd_t cmd,
  output rspa_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  output rspa_pkg::out_item_t      out_item
);
  import rspa_pkg::*;

  localparam int IDX_W   = $clog2(POOL_SLOTS);
  localparam int NGROUPS = (POOL_SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int SW      = $clog2(NGROUPS + 1);
  localparam int XW      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int AW      = GW + OFF_W + 1;
  localparam logic [CNT_W-1:0] CNT_INIT =
    CNT_W'((POOL_SLOTS > CNT_MAX) ? CNT_MAX : POOL_SLOTS);

  logic [IDX_W-1:0] start_tab [SLOT_CODES];
  for (genvar i = 0; i < SLOT_CODES; i++) begin : g_start_tab
    assign start_tab[i] = IDX_W'((i + 1) % POOL_SLOTS);
  end

  logic [ROW_W-1:0]   row_mem_r [NGROUPS];
  logic [NGROUPS-1:0] row_vld_r;
  logic [ROW_W-1:0]   rd_row_r;
  logic               rd_vld_r;

  logic [1:0]         op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [OFF_W-1:0]   off_r;
  logic [GW-1:0]      grp_r, grp_nxt;
  logic [SW-1:0]      step_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [IDX_W-1:0]   start_idx;
  logic [XW-1:0]      slot_x;
  logic               in_range;
  logic               fast_fail;
  logic [GW-1:0]      rd_addr;
  logic               rd_en;
  logic [OFF_W-1:0]   acc_off;

  logic [ROW_W-1:0]   row_eff;
  logic [1:0]         want;
  logic [SCAN_W-1:0]  match;
  logic [OFF_W-1:0]   hit_pos;
  logic [OFF_W-1:0]   wr_pos;
  logic [1:0]         wr_code;
  logic [ROW_W-1:0]   row_new;
  logic [SLOT_W-1:0]  res_slot;

  assign start_idx = start_tab[in_item.slot];
  assign slot_x    = XW'(in_item.slot);
  assign in_range  = (AW'(0) + (XW + 1)'(slot_x)) < (XW + 1)'(POOL_SLOTS);
  assign fast_fail = (in_item.op != OP_FILL && in_item.op != OP_ALLOC &&
                      in_item.op != OP_FREE) ||
                     (in_item.op == OP_ALLOC && count_r == '0) ||
                     (in_item.op == OP_FREE && !in_range);

  assign grp_nxt = (grp_r == GW'(NGROUPS - 1)) ? '0 : grp_r + GW'(1);

  always_comb begin
    rd_addr = grp_nxt;
    acc_off = OFF_W'(start_idx);
    if (cmd.accept) begin
      if (in_item.op == OP_FREE) begin
        rd_addr = GW'(slot_x >> OFF_W);
        acc_off = OFF_W'(slot_x);
      end else begin
        rd_addr = GW'(start_idx >> OFF_W);
      end
    end
  end

  assign rd_en = (cmd.accept && !fast_fail) || cmd.next;

  // scan of the row held in the read register
  assign row_eff = rd_vld_r ? rd_row_r : ROW_FULL;
  assign want    = (op_r == OP_FILL) ? ST_EMPTY : ST_FULL;

  always_comb begin
    for (int p = 0; p < SCAN_W; p++) begin
      logic in_pool;
      logic in_win;
      in_pool = AW'({grp_r, OFF_W'(p)}) < AW'(POOL_SLOTS);
      if (step_r == '0) begin
        in_win = OFF_W'(p) >= off_r;
      end else if (step_r == SW'(NGROUPS)) begin
        in_win = OFF_W'(p) < off_r;
      end else begin
        in_win = 1'b1;
      end
      match[p] = (row_eff[2*p +: 2] == want) && in_pool && in_win;
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int p = SCAN_W - 1; p >= 0; p--) begin
      if (match[p]) begin
        hit_pos = OFF_W'(p);
      end
    end
  end

  always_comb begin
    wr_pos    = hit_pos;
    wr_code   = ST_TAKEN;
    count_nxt = count_r - CNT_W'(1);
    res_slot  = SLOT_W'({grp_r, hit_pos});
    unique case (op_r)
      OP_FILL: begin
        wr_code   = ST_FULL;
        count_nxt = (count_r == CNT_W'(CNT_MAX)) ? count_r : count_r + CNT_W'(1);
      end
      OP_FREE: begin
        wr_pos    = off_r;
        wr_code   = ST_EMPTY;
        count_nxt = count_r;
        res_slot  = slot_r;
      end
      default: begin
      end
    endcase
    for (int p = 0; p < SCAN_W; p++) begin
      row_new[2*p +: 2] = (OFF_W'(p) == wr_pos) ? wr_code : row_eff[2*p +: 2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      row_mem_r[grp_r] <= row_new;
    end
    if (rd_en) begin
      rd_row_r <= row_mem_r[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_item.op;
      slot_r <= in_item.slot;
      off_r  <= acc_off;
    end
    if (rd_en) begin
      grp_r <= rd_addr;
    end
    if (cmd.accept) begin
      step_r <= '0;
    end else if (cmd.next) begin
      step_r <= step_r + SW'(1);
    end
    if (cmd.accept && fast_fail) begin
      out_item_r <= '{result_slot: in_item.slot, found: 1'b0, full_slots: count_r};
    end else if (cmd.fail) begin
      out_item_r <= '{result_slot: slot_r, found: 1'b0, full_slots: count_r};
    end else if (cmd.write) begin
      out_item_r <= '{result_slot: res_slot, found: 1'b1, full_slots: count_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      count_r     <= CNT_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write) begin
        row_vld_r[grp_r] <= 1'b1;
        count_r          <= count_nxt;
      end
      out_valid_r <= (cmd.accept && fast_fail) || cmd.fail || cmd.write;
    end
  end

  assign stat.fast_fail = fast_fail;
  assign stat.is_free   = (in_item.op == OP_FREE);
  assign stat.hit       = |match;
  assign stat.last      = (step_r == SW'(NGROUPS));
  assign out_valid      = out_valid_r;
  assign out_item       = out_item_r;

`ifndef SYNTHESIS
  a_alloc_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && op_r == OP_ALLOC) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("allocation did not decrement the full count");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next |-> (step_r < SW'(NGROUPS)))
    else $error("scan step ran beyond the wrap row");

  a_write_reports_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (out_valid_r && out_item_r.found))
    else $error("state write without a found result beat");
`endif

endmodule

`default_nettype wire

FILE: test/ring_slot_pool_allocator_top_tb.sv
// Self-checking testbench for ring_slot_pool_allocator_top: fill, alloc and free beats
// are checked against a slot pool predictor held in a small scoreboard class.
// Depends on rspa_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module ring_slot_pool_allocator_top_tb;
  import rspa_pkg::*;

  localparam int POOL = 64;
  localparam int NO_HIT = -1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  class slot_pool_scoreboard;
    logic [1:0]       slot_st [POOL];
    logic [CNT_W-1:0] full_cnt;
    out_item_t        pending [$];
    int               errors;
    int               checked;
    int               misses;
    int               cnt_hi;
    int               cnt_lo;

    function new();
      foreach (slot_st[i]) slot_st[i] = ST_FULL;
      full_cnt = CNT_W'((POOL > CNT_MAX) ? CNT_MAX : POOL);
      cnt_hi = int'(full_cnt);
      cnt_lo = int'(full_cnt);
    endfunction

    // ring search starting at the slot after 'from'
    function int next_in_state(int from, logic [1:0] want);
      int idx;
      idx = (from + 1) % POOL;
      for (int k = 0; k < POOL; k++) begin
        if (slot_st[idx] == want) return idx;
        idx = (idx + 1) % POOL;
      end
      return NO_HIT;
    endfunction

    function void note_beat(in_item_t beat);
      out_item_t exp;
      int hit;
      exp.result_slot = beat.slot;
      exp.found = 1'b0;
      hit = NO_HIT;
      case (beat.op)
        OP_FILL: begin
          hit = next_in_state(int'(beat.slot), ST_EMPTY);
          if (hit != NO_HIT) begin
            slot_st[hit] = ST_FULL;
            if (full_cnt < CNT_W'(CNT_MAX)) full_cnt++;
          end
        end
        OP_ALLOC: begin
          if (full_cnt != '0) begin
            hit = next_in_state(int'(beat.slot), ST_FULL);
            if (hit != NO_HIT) begin
              slot_st[hit] = ST_TAKEN;
              full_cnt--;
            end
          end
        end
        OP_FREE: begin
          if (int'(beat.slot) < POOL) begin
            slot_st[beat.slot] = ST_EMPTY;
            exp.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (hit != NO_HIT) begin
        exp.result_slot = hit[SLOT_W-1:0];
        exp.found = 1'b1;
      end
      exp.full_slots = full_cnt;
      pending.push_back(exp);
      if (!exp.found) misses++;
      if (int'(full_cnt) > cnt_hi) cnt_hi = int'(full_cnt);
      if (int'(full_cnt) < cnt_lo) cnt_lo = int'(full_cnt);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got slot %0d found %0d full %0d",
                 $time, got.result_slot, got.found, got.full_slots);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.result_slot !== exp.result_slot) begin
        $display("%0t: result_slot expected %0d got %0d", $time, exp.result_slot,
                 got.result_slot);
        errors++;
      end
      if (got.found !== exp.found) begin
        $display("%0t: found expected %0d got %0d", $time, exp.found, got.found);
        errors++;
      end
      if (got.full_slots !== exp.full_slots) begin
        $display("%0t: full_slots expected %0d got %0d", $time, exp.full_slots,
                 got.full_slots);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  slot_pool_scoreboard sb;
  int        burst_left;
  int        issued;
  int        cycles;

  ring_slot_pool_allocator_top #(
    .POOL_SLOTS(POOL)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_beat(in_item);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, sb.pending.size());
      $display("ring_slot_pool_allocator_top verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge once the beat is taken
  task automatic drive_beat(logic [1:0] op, int slot);
    in_item_t beat;
    int gap;
    beat.op = op;
    beat.slot = slot[SLOT_W-1:0];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    burst_left--;
    issued++;
    @(negedge clk);
  endtask

  task automatic alloc_run(int n);
    repeat (n) drive_beat(OP_ALLOC, $urandom_range(0, POOL - 1));
  endtask

  initial begin
    int base;
    int r;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pool starts all full
    drive_beat(OP_FILL, 63);      // no empty slot
    drive_beat(OP_UNUSED, 0);
    drive_beat(OP_UNUSED, 63);
    drive_beat(OP_ALLOC, 63);     // wraps to slot 0
    drive_beat(OP_ALLOC, 0);
    drive_beat(OP_ALLOC, 62);
    drive_beat(OP_ALLOC, 62);     // skips taken slots across the wrap
    drive_beat(OP_FREE, 0);
    drive_beat(OP_FREE, 0);       // free of an empty slot
    drive_beat(OP_FREE, 63);
    drive_beat(OP_FILL, 62);
    drive_beat(OP_FILL, 63);      // wraps to slot 0
    drive_beat(OP_FILL, 0);       // no empty slot left
    drive_beat(OP_FILL, 5);
    drive_beat(OP_FREE, 1);
    drive_beat(OP_FILL, 63);

    // drain to a zero count, then alloc fails at once
    alloc_run(70);
    base = $urandom_range(0, POOL - 1);
    for (int i = 0; i < POOL; i++) drive_beat(OP_FREE, (base + i) % POOL);
    repeat (POOL) drive_beat(OP_FILL, $urandom_range(0, POOL - 1));
    // free full slots and refill: count climbs into saturation
    repeat (66) begin
      drive_beat(OP_FREE, $urandom_range(0, POOL - 1));
      drive_beat(OP_FILL, $urandom_range(0, POOL - 1));
    end
    // count stays above zero with no full slot left
    alloc_run(70);

    while (issued < 470) begin
      r = $urandom_range(0, 9);
      if (r < 3) drive_beat(OP_FILL, $urandom_range(0, POOL - 1));
      else if (r < 6) drive_beat(OP_ALLOC, $urandom_range(0, POOL - 1));
      else if (r < 9) drive_beat(OP_FREE, $urandom_range(0, POOL - 1));
      else drive_beat(OP_UNUSED, $urandom_range(0, POOL - 1));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d op beats driven, %0d results compared, %0d answered not found",
             issued, sb.checked, sb.misses);
    $display("full count ranged from %0d to %0d", sb.cnt_lo, sb.cnt_hi);
    if (sb.errors == 0) begin
      $display("ring_slot_pool_allocator_top verification clean");
    end else begin
      $display("ring_slot_pool_allocator_top verification failed");
    end
    $finish;
  end

endmodule
